// File: rtl/core/confusion_matrix_accumulator_assert.svh
// Assertion macros for the confusion matrix accumulator.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CONFUSION_MATRIX_ACCUMULATOR_ASSERT_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

// File: rtl/core/cma_pkg.sv
// Shared types and constants of the confusion matrix accumulator.
// No dependencies.
package cma_pkg;

  localparam int ClassW = 4;
  localparam int OutW = 16;
  localparam int IdxSize = 16;
  localparam int CellDepth = IdxSize * IdxSize;
  localparam int FifoDepth = 3;
  localparam int FifoPtrW = 2;

  localparam logic [ClassW-1:0] MaxClasses = 4'd15;
  localparam logic [ClassW-1:0] ClassCountReset = 4'd15;

  typedef struct packed {
    logic [OutW-1:0] cell_count;
    logic [OutW-1:0] total_count;
    logic [OutW-1:0] correct_count;
    logic [OutW-1:0] seen_count;
    logic [OutW-1:0] seen_correct_count;
    logic [OutW-1:0] unseen_correct_count;
    logic [OutW-1:0] class_predicted_count;
    logic [OutW-1:0] class_correct_count;
    logic            is_correct;
    logic            range_error;
  } result_t;

endpackage

// File: rtl/core/confusion_matrix_accumulator.sv
// Confusion matrix accumulator top level; depends on cma_pkg, cma_store and cma_out_fifo.
// An accepted word is registered in the update stage and then queued for the output.
// Throughput: one word per cycle while input ready is high, set by the read-modify-write
// of the matrix RAM and the class RAM, with the last write forwarded to the next read.
// A three-entry result queue absorbs output stalls; input ready drops while the queue and
// the update stage hold three words. Reset clears all counters and sets class_count to 15.
module confusion_matrix_accumulator #(
  parameter int COUNT_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_data_i,      // class_count
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // true_class[3:0], predicted_class[7:4]
  input  logic [0:0]   s_axis_tuser_i,  // seen_in_training[0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cell_count[15:0], total_count[31:16], correct_count[47:32], seen_count[63:48],
  // seen_correct_count[79:64], unseen_correct_count[95:80],
  // class_predicted_count[111:96], class_correct_count[127:112]
  output logic [127:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o   // is_correct[0], range_error[1]
);

  `include "confusion_matrix_accumulator_assert.svh"

  localparam int OutW = cma_pkg::OutW;
  localparam int ClassW = cma_pkg::ClassW;
  localparam int CellAw = $clog2(cma_pkg::CellDepth);
  localparam logic [cma_pkg::FifoPtrW:0] FifoSlots = (cma_pkg::FifoPtrW + 1)'(cma_pkg::FifoDepth);
  localparam logic [cma_pkg::FifoPtrW-1:0] FifoFull = cma_pkg::FifoPtrW'(cma_pkg::FifoDepth);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  logic                     accept;
  logic [ClassW-1:0]        true_cls, pred_cls, limit;
  logic                     err_in, ok_in;
  logic [ClassW-1:0]        class_count_q;

  logic                     s1_vld_q, s1_err_q, s1_ok_q, s1_seen_q;
  logic                     cnt_en;

  logic [COUNT_BITS-1:0]    cell_cur, cell_new;
  logic [2*COUNT_BITS-1:0]  pred_cur, pred_new;
  logic [COUNT_BITS-1:0]    ptot_new, pcor_new;

  logic [COUNT_BITS-1:0]    total_q, total_d;
  logic [COUNT_BITS-1:0]    correct_q, correct_d;
  logic [COUNT_BITS-1:0]    seen_q, seen_d;
  logic [COUNT_BITS-1:0]    seen_cor_q, seen_cor_d;
  logic [COUNT_BITS-1:0]    unseen_cor_q, unseen_cor_d;

  cma_pkg::result_t                 res, head;
  logic [cma_pkg::FifoPtrW-1:0]     fifo_cnt;
  logic [cma_pkg::FifoPtrW:0]       in_flight;

  assign true_cls = s_axis_tdata_i[3:0];
  assign pred_cls = s_axis_tdata_i[7:4];
  assign limit    = (class_count_q < cma_pkg::MaxClasses) ? class_count_q : cma_pkg::MaxClasses;
  assign err_in   = (true_cls > limit) || (pred_cls > limit);
  assign ok_in    = (true_cls == pred_cls);

  assign in_flight       = {1'b0, fifo_cnt} + {{cma_pkg::FifoPtrW{1'b0}}, s1_vld_q};
  assign s_axis_tready_o = (in_flight < FifoSlots);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= cma_pkg::ClassCountReset;
    end else if (cfg_valid_i) begin
      class_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_err_q  <= err_in;
      s1_ok_q   <= ok_in;
      s1_seen_q <= s_axis_tuser_i[0];
    end
  end

  assign cnt_en = s1_vld_q && !s1_err_q;

  cma_store #(
    .Width(COUNT_BITS),
    .Depth(cma_pkg::CellDepth)
  ) u_cell_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(CellAw'({true_cls, pred_cls})),
    .wr_en_i  (cnt_en),
    .wr_data_i(cell_new),
    .rdata_o  (cell_cur)
  );

  cma_store #(
    .Width(2 * COUNT_BITS),
    .Depth(cma_pkg::IdxSize)
  ) u_class_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(pred_cls),
    .wr_en_i  (cnt_en),
    .wr_data_i(pred_new),
    .rdata_o  (pred_cur)
  );

  always_comb begin
    cell_new     = cnt_en ? sat_inc(cell_cur) : cell_cur;
    ptot_new     = cnt_en ? sat_inc(pred_cur[COUNT_BITS-1:0]) : pred_cur[COUNT_BITS-1:0];
    pcor_new     = (cnt_en && s1_ok_q) ? sat_inc(pred_cur[2*COUNT_BITS-1:COUNT_BITS])
                                       : pred_cur[2*COUNT_BITS-1:COUNT_BITS];
    pred_new     = {pcor_new, ptot_new};
    total_d      = cnt_en ? sat_inc(total_q) : total_q;
    correct_d    = (cnt_en && s1_ok_q) ? sat_inc(correct_q) : correct_q;
    seen_d       = (cnt_en && s1_seen_q) ? sat_inc(seen_q) : seen_q;
    seen_cor_d   = (cnt_en && s1_ok_q && s1_seen_q) ? sat_inc(seen_cor_q) : seen_cor_q;
    unseen_cor_d = (cnt_en && s1_ok_q && !s1_seen_q) ? sat_inc(unseen_cor_q) : unseen_cor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      correct_q    <= '0;
      seen_q       <= '0;
      seen_cor_q   <= '0;
      unseen_cor_q <= '0;
    end else begin
      total_q      <= total_d;
      correct_q    <= correct_d;
      seen_q       <= seen_d;
      seen_cor_q   <= seen_cor_d;
      unseen_cor_q <= unseen_cor_d;
    end
  end

  always_comb begin
    res.cell_count            = OutW'(cell_new);
    res.total_count           = OutW'(total_d);
    res.correct_count         = OutW'(correct_d);
    res.seen_count            = OutW'(seen_d);
    res.seen_correct_count    = OutW'(seen_cor_d);
    res.unseen_correct_count  = OutW'(unseen_cor_d);
    res.class_predicted_count = OutW'(ptot_new);
    res.class_correct_count   = OutW'(pcor_new);
    res.is_correct            = s1_ok_q;
    res.range_error           = s1_err_q;
  end

  cma_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_vld_q),
    .push_data_i(res),
    .pop_i      (m_axis_tready_i),
    .data_o     (head),
    .valid_o    (m_axis_tvalid_o),
    .count_o    (fifo_cnt)
  );

  assign m_axis_tdata_o = {head.class_correct_count, head.class_predicted_count,
                           head.unseen_correct_count, head.seen_correct_count,
                           head.seen_count, head.correct_count,
                           head.total_count, head.cell_count};
  assign m_axis_tuser_o = {head.range_error, head.is_correct};

  `CMA_ASSERT_NEXT(a_accept_enters_update, accept, s1_vld_q)
  `CMA_ASSERT_SAME(a_queue_has_room, s1_vld_q, fifo_cnt != FifoFull)
  `CMA_ASSERT_NEXT(a_error_counts_nothing, s1_vld_q && s1_err_q, $stable(total_q))

endmodule

// File: rtl/core/cma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cma_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cma_store.sv
// Counter store: a RAM with per-entry valid bits and write forwarding.
// Depends on cma_ram.
module cma_store #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [Aw-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rdata_o
);

  logic [Aw-1:0]    addr_q;
  logic [Depth-1:0] valid_q;
  logic             fwd_vld_q;
  logic [Aw-1:0]    fwd_addr_q;
  logic [Width-1:0] fwd_data_q;
  logic [Width-1:0] ram_rdata;

  cma_ram #(
    .Width(Width),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(addr_q),
    .wdata_i(wr_data_i),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q <= rd_addr_i;
    end
    if (wr_en_i) begin
      fwd_addr_q <= addr_q;
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fwd_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q[addr_q] <= 1'b1;
      fwd_vld_q       <= 1'b1;
    end
  end

  // The RAM returns old data when the entry was written in the same cycle as the read.
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == addr_q)) begin
      rdata_o = fwd_data_q;
    end else if (valid_q[addr_q]) begin
      rdata_o = ram_rdata;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

// File: rtl/core/cma_out_fifo.sv
// Small result queue between the update stage and the output stream.
// Depends on cma_pkg.
module cma_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  cma_pkg::result_t               push_data_i,
  input  logic                           pop_i,
  output cma_pkg::result_t               data_o,
  output logic                           valid_o,
  output logic [cma_pkg::FifoPtrW-1:0]   count_o
);

  localparam logic [cma_pkg::FifoPtrW-1:0] LastPtr =
    cma_pkg::FifoPtrW'(cma_pkg::FifoDepth - 1);

  cma_pkg::result_t                 mem_q [cma_pkg::FifoDepth];
  logic [cma_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [cma_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [cma_pkg::FifoPtrW-1:0]     count_q, count_d;
  logic                             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for confusion_matrix_accumulator: random and directed items,
// with the confusion counts predicted and compared word by word. Depends on cma_pkg.
module testbench;

  localparam int QuietLimit = 2000;

  class confusion_tally;
    logic [cma_pkg::OutW-1:0] cells [cma_pkg::IdxSize][cma_pkg::IdxSize];
    logic [cma_pkg::OutW-1:0] pred_total [cma_pkg::IdxSize];
    logic [cma_pkg::OutW-1:0] pred_correct [cma_pkg::IdxSize];
    logic [cma_pkg::OutW-1:0] n_total, n_correct, n_seen, n_seen_correct, n_unseen_correct;
    logic [cma_pkg::ClassW-1:0] class_limit;
    cma_pkg::result_t pending_counts [$];
    int bad_fields;

    function new();
      foreach (cells[i, j]) cells[i][j] = '0;
      foreach (pred_total[i]) begin
        pred_total[i] = '0;
        pred_correct[i] = '0;
      end
      n_total = '0;
      n_correct = '0;
      n_seen = '0;
      n_seen_correct = '0;
      n_unseen_correct = '0;
      class_limit = cma_pkg::ClassCountReset;
      bad_fields = 0;
    endfunction

    function logic [cma_pkg::OutW-1:0] bump(logic [cma_pkg::OutW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void record_item(logic [cma_pkg::ClassW-1:0] t, logic [cma_pkg::ClassW-1:0] p,
                              logic seen);
      logic [cma_pkg::ClassW-1:0] lim;
      logic err, hit;
      cma_pkg::result_t r;
      lim = (class_limit < cma_pkg::MaxClasses) ? class_limit : cma_pkg::MaxClasses;
      err = (t > lim) || (p > lim);
      hit = (t == p);
      if (!err) begin
        cells[t][p] = bump(cells[t][p]);
        pred_total[p] = bump(pred_total[p]);
        n_total = bump(n_total);
        if (seen) n_seen = bump(n_seen);
        if (hit) begin
          pred_correct[p] = bump(pred_correct[p]);
          n_correct = bump(n_correct);
          if (seen) n_seen_correct = bump(n_seen_correct);
          else n_unseen_correct = bump(n_unseen_correct);
        end
      end
      r.cell_count = cells[t][p];
      r.total_count = n_total;
      r.correct_count = n_correct;
      r.seen_count = n_seen;
      r.seen_correct_count = n_seen_correct;
      r.unseen_correct_count = n_unseen_correct;
      r.class_predicted_count = pred_total[p];
      r.class_correct_count = pred_correct[p];
      r.is_correct = hit;
      r.range_error = err;
      pending_counts.push_back(r);
    endfunction

    function void match(string field, logic [cma_pkg::OutW-1:0] want,
                        logic [cma_pkg::OutW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        bad_fields++;
      end
    endfunction

    function void compare_counts(logic [127:0] data, logic [1:0] flags);
      cma_pkg::result_t want;
      if (pending_counts.size() == 0) begin
        $error("Result word arrived while no counts were expected.");
        bad_fields++;
        return;
      end
      want = pending_counts.pop_front();
      match("cell_count", want.cell_count, data[15:0]);
      match("total_count", want.total_count, data[31:16]);
      match("correct_count", want.correct_count, data[47:32]);
      match("seen_count", want.seen_count, data[63:48]);
      match("seen_correct_count", want.seen_correct_count, data[79:64]);
      match("unseen_correct_count", want.unseen_correct_count, data[95:80]);
      match("class_predicted_count", want.class_predicted_count, data[111:96]);
      match("class_correct_count", want.class_correct_count, data[127:112]);
      match("is_correct", cma_pkg::OutW'(want.is_correct), cma_pkg::OutW'(flags[0]));
      match("range_error", cma_pkg::OutW'(want.range_error), cma_pkg::OutW'(flags[1]));
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [3:0]   cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;   // true_class[3:0], predicted_class[7:4]
  logic [0:0]   s_axis_tuser_i = '0;   // seen_in_training[0]
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;        // cell_count up to class_correct_count, 16 bits each
  logic [1:0]   m_axis_tuser_o;        // is_correct[0], range_error[1]

  confusion_tally tally = new();
  int src_idle = 0;
  int sink_idle = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  confusion_matrix_accumulator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) tally.class_limit = cfg_data_i;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      tally.record_item(s_axis_tdata_i[3:0], s_axis_tdata_i[7:4], s_axis_tuser_i[0]);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) tally.compare_counts(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver either sits out a requested long stall or stalls at random.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready_i <= (int'($urandom_range(99)) >= sink_idle);
      end
    end
  end

  task automatic send_item(logic [3:0] t, logic [3:0] p, logic seen);
    while (int'($urandom_range(99)) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {p, t};
    s_axis_tuser_i <= seen;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (tally.pending_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_class_count(logic [3:0] value);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(int n);
    logic [3:0] lim, t, p;
    int r;
    repeat (n) begin
      lim = (tally.class_limit < cma_pkg::MaxClasses) ? tally.class_limit : cma_pkg::MaxClasses;
      r = int'($urandom_range(99));
      if (r < 12) begin
        t = 4'($urandom_range(15));
        p = 4'($urandom_range(15));
      end else begin
        t = 4'($urandom_range(int'(lim)));
        p = (r < 50) ? t : 4'($urandom_range(int'(lim)));
      end
      send_item(t, p, 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int chunks);
    src_idle = src_pct;
    sink_idle = sink_pct;
    repeat (chunks) begin
      write_class_count(4'($urandom_range(15)));
      send_random(100);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle = 15;
    sink_idle = 79;

    // Default class count: unknown matched by unknown, both extremes, a wrong guess.
    send_item(4'd0, 4'd0, 1'b0);
    send_item(4'd0, 4'd0, 1'b1);
    send_item(4'd15, 4'd15, 1'b1);
    send_item(4'd15, 4'd0, 1'b0);
    send_item(4'd0, 4'd15, 1'b1);
    send_item(4'd3, 4'd5, 1'b0);
    send_item(4'd5, 4'd5, 1'b1);
    send_item(4'd5, 4'd5, 1'b0);
    // With no real classes only the unknown class is in range.
    write_class_count(4'd0);
    send_item(4'd0, 4'd0, 1'b1);
    send_item(4'd1, 4'd0, 1'b0);
    send_item(4'd0, 4'd1, 1'b1);
    send_item(4'd15, 4'd15, 1'b0);
    write_class_count(4'd1);
    send_item(4'd1, 4'd1, 1'b1);
    send_item(4'd1, 4'd0, 1'b0);
    send_item(4'd2, 4'd1, 1'b0);
    send_item(4'd1, 4'd2, 1'b1);
    write_class_count(4'd7);
    send_item(4'd7, 4'd7, 1'b0);
    send_item(4'd8, 4'd7, 1'b1);
    send_item(4'd7, 4'd8, 1'b0);

    run_phase(15, 79, 5);
    run_phase(79, 15, 5);

    src_idle = 0;
    sink_idle = 0;
    write_class_count(4'd15);
    hold_cycles = 400;
    send_random(100);
    run_phase(0, 0, 6);

    write_class_count(4'd15);
    send_random(30);

    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tally.bad_fields == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
